>>> hw/rtl/ia32e_pkg.sv
package ia32e_pkg;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;
    localparam logic [1:0] KIND_MEM = 2'd2;

    localparam logic [4:0] OP_RET   = 5'd0;
    localparam logic [4:0] OP_NOP   = 5'd1;
    localparam logic [4:0] OP_INT   = 5'd2;
    localparam logic [4:0] OP_JMP   = 5'd3;
    localparam logic [4:0] OP_CALL  = 5'd4;
    localparam logic [4:0] OP_JE    = 5'd5;
    localparam logic [4:0] OP_JLE   = 5'd10;
    localparam logic [4:0] OP_PUSH  = 5'd11;
    localparam logic [4:0] OP_POP   = 5'd12;
    localparam logic [4:0] OP_INC   = 5'd13;
    localparam logic [4:0] OP_IMUL  = 5'd18;
    localparam logic [4:0] OP_IDIV  = 5'd20;
    localparam logic [4:0] OP_LEA   = 5'd21;
    localparam logic [4:0] OP_MOVZX = 5'd22;
    localparam logic [4:0] OP_MOV   = 5'd23;
    localparam logic [4:0] OP_ADD   = 5'd24;
    localparam logic [4:0] OP_CMP   = 5'd29;

    localparam int MAX_BYTES = 11;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_KIND  = 2'd2,
        ST_OP    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        IMM_NONE = 2'd0,
        IMM_8    = 2'd1,
        IMM_32   = 2'd2
    } imm_mode_t;

    typedef enum logic [1:0] {
        DSZ_0  = 2'd0,
        DSZ_8  = 2'd1,
        DSZ_32 = 2'd2
    } disp_size_t;

    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  operand_count;
        logic [1:0]  kind_a;
        logic [1:0]  kind_b;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic [3:0]  mem_base;
        logic [3:0]  mem_index;
        logic [3:0]  mem_scale;
        logic signed [31:0] mem_disp;
        logic signed [31:0] imm_value;
        logic [1:0]  sym_flags;
    } instr_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic [1:0] status;
        logic       reloc_start;
        logic       reloc_kind;
    } code_t;

    typedef struct packed {
        status_t    status;
        logic       two_op;
        logic [7:0] op0;
        logic [7:0] op1;
        logic       has_rm;
        logic [2:0] rf;
        logic [1:0] rm_kind;
        logic [2:0] rm_reg;
        logic [3:0] base;
        logic [3:0] index;
        logic [3:0] scale;
        logic [31:0] disp;
        logic       dsym;
        imm_mode_t  imm_mode;
        logic [31:0] imm;
        logic       isym;
        logic       irel;
    } dec_t;

    typedef struct packed {
        status_t    status;
        logic       two_op;
        logic [7:0] op0;
        logic [7:0] op1;
        logic       has_rm;
        logic [7:0] modrm;
        logic       has_sib;
        logic [7:0] sib;
        disp_size_t dsz;
        logic [31:0] disp;
        logic       dsym;
        imm_mode_t  imm_mode;
        logic [31:0] imm;
        logic       isym;
        logic       irel;
    } addr_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      rs;
        logic [MAX_BYTES-1:0]      rk;
        logic [3:0]                cnt;
        status_t                   status;
    } pack_t;

    function automatic logic [7:0] jcc_byte(input logic [2:0] x);
        logic [7:0] r;
        case (x)
            3'd0:    r = 8'h84;
            3'd1:    r = 8'h85;
            3'd2:    r = 8'h8F;
            3'd3:    r = 8'h8D;
            3'd4:    r = 8'h8C;
            default: r = 8'h8E;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] alu_byte(input logic [2:0] x);
        logic [7:0] r;
        case (x)
            3'd0:    r = 8'h01;
            3'd1:    r = 8'h09;
            3'd2:    r = 8'h21;
            3'd3:    r = 8'h29;
            3'd4:    r = 8'h31;
            default: r = 8'h39;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] alu_digit(input logic [2:0] x);
        logic [2:0] r;
        case (x)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd1;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd5;
            3'd4:    r = 3'd6;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/ia32e_decode.sv
module ia32e_decode
    import ia32e_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid,
    input  instr_t instr,
    input  logic   nxt_rdy,
    output logic   rdy,
    output logic   dec_valid,
    output dec_t   dec
);

    logic v_reg;
    dec_t d_reg;
    dec_t d_next;

    logic [1:0] ka;
    logic [1:0] kb;
    logic [1:0] n;
    logic [2:0] ra;
    logic [2:0] rb;
    logic [2:0] d;
    logic [2:0] ax;
    logic [4:0] jx;
    logic       isym;
    logic       ka_rm;
    logic       kb_rm;

    assign rdy       = !v_reg || nxt_rdy;
    assign dec_valid = v_reg;
    assign dec       = d_reg;

    assign ka   = instr.kind_a;
    assign kb   = instr.kind_b;
    assign n    = instr.operand_count;
    assign ra   = instr.reg_a;
    assign rb   = instr.reg_b;
    assign isym = instr.sym_flags[1];
    assign d    = 3'(instr.op - OP_INC);
    assign ax   = 3'(instr.op - OP_ADD);
    assign jx   = instr.op - OP_JE;
    assign ka_rm = (ka == KIND_REG) || (ka == KIND_MEM);
    assign kb_rm = (kb == KIND_REG) || (kb == KIND_MEM);

    always_comb
    begin
        d_next          = '0;
        d_next.status   = ST_OK;
        d_next.imm_mode = IMM_NONE;
        d_next.base     = instr.mem_base;
        d_next.index    = instr.mem_index;
        d_next.scale    = instr.mem_scale;
        d_next.disp     = instr.mem_disp;
        d_next.dsym     = instr.sym_flags[0];
        d_next.imm      = instr.imm_value;
        d_next.isym     = isym;
        unique case (instr.op) inside
            OP_RET, OP_NOP:
            begin
                if (n != 2'd0)
                    d_next.status = ST_COUNT;
                d_next.op0 = (instr.op == OP_RET) ? 8'hC3 : 8'h90;
            end
            OP_INT:
            begin
                if (n != 2'd1)
                    d_next.status = ST_COUNT;
                else if (ka != KIND_IMM || isym)
                    d_next.status = ST_KIND;
                d_next.op0      = 8'hCD;
                d_next.imm_mode = IMM_8;
            end
            [OP_JMP:OP_JLE]:
            begin
                if (n != 2'd1)
                    d_next.status = ST_COUNT;
                else if (ka != KIND_IMM)
                    d_next.status = ST_KIND;
                d_next.imm_mode = IMM_32;
                d_next.irel     = 1'b1;
                if (instr.op == OP_JMP)
                    d_next.op0 = 8'hE9;
                else if (instr.op == OP_CALL)
                    d_next.op0 = 8'hE8;
                else
                begin
                    d_next.op0    = 8'h0F;
                    d_next.two_op = 1'b1;
                    d_next.op1    = jcc_byte(jx[2:0]);
                end
            end
            OP_PUSH, OP_POP:
            begin
                if (n != 2'd1)
                    d_next.status = ST_COUNT;
                else if (ka == KIND_REG)
                    d_next.op0 = ((instr.op == OP_PUSH) ? 8'h50 : 8'h58) + {5'd0, ra};
                else if (ka == KIND_IMM && instr.op == OP_PUSH)
                begin
                    d_next.op0      = 8'h68;
                    d_next.imm_mode = IMM_32;
                end
                else if (ka == KIND_MEM)
                begin
                    d_next.op0     = (instr.op == OP_PUSH) ? 8'hFF : 8'h8F;
                    d_next.has_rm  = 1'b1;
                    d_next.rf      = (instr.op == OP_PUSH) ? 3'd6 : 3'd0;
                    d_next.rm_kind = ka;
                    d_next.rm_reg  = ra;
                end
                else
                    d_next.status = ST_KIND;
            end
            [OP_INC:OP_IDIV]:
            begin
                d_next.has_rm = 1'b1;
                if (instr.op == OP_IMUL && n == 2'd2)
                begin
                    if (ka != KIND_REG)
                        d_next.status = ST_KIND;
                    d_next.op0     = 8'h0F;
                    d_next.two_op  = 1'b1;
                    d_next.op1     = 8'hAF;
                    d_next.rf      = ra;
                    d_next.rm_kind = kb;
                    d_next.rm_reg  = rb;
                end
                else
                begin
                    if (n != 2'd1)
                        d_next.status = ST_COUNT;
                    else if (!ka_rm)
                        d_next.status = ST_KIND;
                    d_next.op0     = (d < 3'd2) ? 8'hFF : 8'hF7;
                    d_next.rf      = d;
                    d_next.rm_kind = ka;
                    d_next.rm_reg  = ra;
                end
            end
            OP_LEA, OP_MOVZX:
            begin
                if (n != 2'd2)
                    d_next.status = ST_COUNT;
                else if (ka != KIND_REG || ((instr.op == OP_LEA) ? (kb != KIND_MEM) : !kb_rm))
                    d_next.status = ST_KIND;
                if (instr.op == OP_LEA)
                    d_next.op0 = 8'h8D;
                else
                begin
                    d_next.op0    = 8'h0F;
                    d_next.two_op = 1'b1;
                    d_next.op1    = 8'hB6;
                end
                d_next.has_rm  = 1'b1;
                d_next.rf      = ra;
                d_next.rm_kind = kb;
                d_next.rm_reg  = rb;
            end
            OP_MOV:
            begin
                if (n != 2'd2)
                    d_next.status = ST_COUNT;
                else if (ka == KIND_REG && kb == KIND_IMM)
                begin
                    d_next.op0      = 8'hB8 + {5'd0, ra};
                    d_next.imm_mode = IMM_32;
                end
                else if (ka == KIND_REG && kb_rm)
                begin
                    d_next.op0     = 8'h8B;
                    d_next.has_rm  = 1'b1;
                    d_next.rf      = ra;
                    d_next.rm_kind = kb;
                    d_next.rm_reg  = rb;
                end
                else if (ka == KIND_MEM && kb == KIND_REG)
                begin
                    d_next.op0     = 8'h89;
                    d_next.has_rm  = 1'b1;
                    d_next.rf      = rb;
                    d_next.rm_kind = ka;
                    d_next.rm_reg  = ra;
                end
                else if (ka == KIND_MEM && kb == KIND_IMM)
                begin
                    d_next.op0      = 8'hC7;
                    d_next.has_rm   = 1'b1;
                    d_next.rm_kind  = ka;
                    d_next.rm_reg   = ra;
                    d_next.imm_mode = IMM_32;
                end
                else
                    d_next.status = ST_KIND;
            end
            [OP_ADD:OP_CMP]:
            begin
                d_next.has_rm = 1'b1;
                if (n != 2'd2)
                    d_next.status = ST_COUNT;
                else if (kb == KIND_IMM)
                begin
                    if (!ka_rm)
                        d_next.status = ST_KIND;
                    d_next.op0      = 8'h81;
                    d_next.rf       = alu_digit(ax);
                    d_next.rm_kind  = ka;
                    d_next.rm_reg   = ra;
                    d_next.imm_mode = IMM_32;
                end
                else if (ka == KIND_REG && kb_rm)
                begin
                    d_next.op0     = alu_byte(ax) + 8'd2;
                    d_next.rf      = ra;
                    d_next.rm_kind = kb;
                    d_next.rm_reg  = rb;
                end
                else if (ka == KIND_MEM && kb == KIND_REG)
                begin
                    d_next.op0     = alu_byte(ax);
                    d_next.rf      = rb;
                    d_next.rm_kind = ka;
                    d_next.rm_reg  = ra;
                end
                else
                    d_next.status = ST_KIND;
            end
            default:
                d_next.status = ST_OP;
        endcase
        if (d_next.status == ST_OK && d_next.has_rm
            && d_next.rm_kind != KIND_REG && d_next.rm_kind != KIND_MEM)
            d_next.status = ST_KIND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && valid)
            d_reg <= d_next;
    end

endmodule

>>> hw/rtl/ia32e_addr.sv
module ia32e_addr
    import ia32e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  dec_valid,
    input  dec_t  dec,
    input  logic  nxt_rdy,
    output logic  rdy,
    output logic  addr_valid,
    output addr_t addr
);

    logic  v_reg;
    addr_t a_reg;
    addr_t a_next;

    logic       nb;
    logic       ni;
    logic [1:0] md;
    logic [1:0] sc;
    logic       fits8;

    assign rdy        = !v_reg || nxt_rdy;
    assign addr_valid = v_reg;
    assign addr       = a_reg;

    assign nb    = dec.base[3];
    assign ni    = dec.index[3];
    assign fits8 = (dec.disp[31:7] == '0) || (dec.disp[31:7] == '1);

    always_comb
    begin
        case (dec.scale)
            4'd2:    sc = 2'd1;
            4'd4:    sc = 2'd2;
            4'd8:    sc = 2'd3;
            default: sc = 2'd0;
        endcase
    end

    always_comb
    begin
        a_next          = '0;
        a_next.status   = dec.status;
        a_next.two_op   = dec.two_op;
        a_next.op0      = dec.op0;
        a_next.op1      = dec.op1;
        a_next.has_rm   = dec.has_rm;
        a_next.dsz      = DSZ_0;
        a_next.disp     = dec.disp;
        a_next.dsym     = dec.dsym;
        a_next.imm_mode = dec.imm_mode;
        a_next.imm      = dec.imm;
        a_next.isym     = dec.isym;
        a_next.irel     = dec.irel;
        md              = 2'd0;
        if (dec.rm_kind == KIND_REG)
            a_next.modrm = {2'b11, dec.rf, dec.rm_reg};
        else if (nb && ni)
        begin
            a_next.modrm = {2'b00, dec.rf, 3'd5};
            a_next.dsz   = DSZ_32;
        end
        else
        begin
            if (nb)
                a_next.dsz = DSZ_32;
            else if (dec.dsym)
            begin
                md         = 2'd2;
                a_next.dsz = DSZ_32;
            end
            else if (dec.disp == '0 && dec.base != 4'd5)
                a_next.dsz = DSZ_0;
            else if (fits8)
            begin
                md         = 2'd1;
                a_next.dsz = DSZ_8;
            end
            else
            begin
                md         = 2'd2;
                a_next.dsz = DSZ_32;
            end
            if (!ni || dec.base == 4'd4 || nb)
            begin
                a_next.modrm   = {md, dec.rf, 3'd4};
                a_next.has_sib = 1'b1;
                a_next.sib     = {sc, (ni ? 3'd4 : dec.index[2:0]),
                                  (nb ? 3'd5 : dec.base[2:0])};
            end
            else
                a_next.modrm = {md, dec.rf, dec.base[2:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && dec_valid)
            a_reg <= a_next;
    end

endmodule

>>> hw/rtl/ia32e_pack.sv
module ia32e_pack
    import ia32e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  addr_valid,
    input  addr_t addr,
    input  logic  nxt_rdy,
    output logic  rdy,
    output logic  pack_valid,
    output pack_t pack
);

    logic  v_reg;
    pack_t p_reg;
    pack_t p_next;
    logic [3:0] p;

    assign rdy        = !v_reg || nxt_rdy;
    assign pack_valid = v_reg;
    assign pack       = p_reg;

    always_comb
    begin
        p_next        = '0;
        p_next.status = addr.status;
        p             = 4'd0;
        if (addr.status != ST_OK)
            p = 4'd1;
        else
        begin
            p_next.bytes[p] = addr.op0;
            p = p + 4'd1;
            if (addr.two_op)
            begin
                p_next.bytes[p] = addr.op1;
                p = p + 4'd1;
            end
            if (addr.has_rm)
            begin
                p_next.bytes[p] = addr.modrm;
                p = p + 4'd1;
                if (addr.has_sib)
                begin
                    p_next.bytes[p] = addr.sib;
                    p = p + 4'd1;
                end
                if (addr.dsz == DSZ_8)
                begin
                    p_next.bytes[p] = addr.disp[7:0];
                    p = p + 4'd1;
                end
                else if (addr.dsz == DSZ_32)
                begin
                    p_next.rs[p] = addr.dsym;
                    for (int k = 0; k < 4; k++)
                    begin
                        p_next.bytes[p] = addr.disp[8*k +: 8];
                        p = p + 4'd1;
                    end
                end
            end
            if (addr.imm_mode == IMM_8)
            begin
                p_next.bytes[p] = addr.imm[7:0];
                p = p + 4'd1;
            end
            else if (addr.imm_mode == IMM_32)
            begin
                p_next.rs[p] = addr.isym;
                p_next.rk[p] = addr.isym && addr.irel;
                for (int k = 0; k < 4; k++)
                begin
                    p_next.bytes[p] = addr.imm[8*k +: 8];
                    p = p + 4'd1;
                end
            end
        end
        p_next.cnt = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= addr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && addr_valid)
            p_reg <= p_next;
    end

endmodule

>>> hw/rtl/ia32e_serial.sv
module ia32e_serial
    import ia32e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pack_valid,
    input  pack_t pack,
    output logic  rdy,
    output logic  valid,
    input  logic  stall,
    output code_t code
);

    logic       v_reg;
    logic       v_next;
    pack_t      buf_reg;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       last;
    logic       done;

    assign last  = (idx_reg == buf_reg.cnt - 4'd1);
    assign done  = v_reg && !stall && last;
    assign rdy   = !v_reg || done;
    assign valid = v_reg;

    assign code.code_byte   = buf_reg.bytes[idx_reg];
    assign code.last        = last;
    assign code.status      = buf_reg.status;
    assign code.reloc_start = buf_reg.rs[idx_reg];
    assign code.reloc_kind  = buf_reg.rk[idx_reg];

    always_comb
    begin
        v_next   = v_reg;
        idx_next = idx_reg;
        if (rdy)
        begin
            v_next   = pack_valid;
            idx_next = 4'd0;
        end
        else if (!stall)
            idx_next = idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            idx_reg <= 4'd0;
        end
        else
        begin
            v_reg   <= v_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && pack_valid)
            buf_reg <= pack;
    end

endmodule

>>> hw/rtl/ia32_instruction_encoder_unit.sv
// channel | direction | handshake            | payload
// instr   | in        | instr_valid/_stall   | instr_t, one instruction per beat
// code    | out       | code_valid/_stall    | code_t, one machine code byte per beat
//
// Three register stages (decode, address form, byte packing) feed a byte serializer.
// An instruction emits 1 to 11 bytes; the serializer sets the rate.
// Path to the first byte: decode, address, pack and serializer registers.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output holds its beat; stages upstream fill and then stall the input.
module ia32_instruction_encoder_unit
    import ia32e_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   instr_valid,
    output logic   instr_stall,
    input  instr_t instr,
    output logic   code_valid,
    input  logic   code_stall,
    output code_t  code
);

    logic  dec_valid;
    dec_t  dec;
    logic  dec_rdy;
    logic  addr_valid;
    addr_t addr;
    logic  addr_rdy;
    logic  pack_valid;
    pack_t pack;
    logic  pack_rdy;
    logic  ser_rdy;

    assign instr_stall = !dec_rdy;

    ia32e_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (instr_valid),
        .instr     (instr),
        .nxt_rdy   (addr_rdy),
        .rdy       (dec_rdy),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    ia32e_addr u_addr
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .nxt_rdy    (pack_rdy),
        .rdy        (addr_rdy),
        .addr_valid (addr_valid),
        .addr       (addr)
    );

    ia32e_pack u_pack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .addr_valid (addr_valid),
        .addr       (addr),
        .nxt_rdy    (ser_rdy),
        .rdy        (pack_rdy),
        .pack_valid (pack_valid),
        .pack       (pack)
    );

    ia32e_serial u_serial
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pack_valid (pack_valid),
        .pack       (pack),
        .rdy        (ser_rdy),
        .valid      (code_valid),
        .stall      (code_stall),
        .code       (code)
    );

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.status != ST_OK |-> code.last && code.code_byte == 8'd0)
        else $error("error beat not single");

    a_kind_start: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code.reloc_start |-> !code.reloc_kind)
        else $error("relocation kind without start");

    a_pack_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid && !ser_rdy |=> pack_valid && $stable(pack))
        else $error("packed instruction lost");

    a_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
        instr_stall |-> dec_valid && addr_valid && pack_valid)
        else $error("input stalled with a free stage");

endmodule

>>> tb/ia32_encoder_checker.sv
`timescale 1ns / 1ps
module ia32_encoder_checker
    import ia32e_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   instr_valid,
    input  logic   instr_stall,
    input  instr_t instr,
    input  logic   code_valid,
    input  logic   code_stall,
    input  code_t  code,
    output int     fail_count,
    output int     pending,
    output int     instr_seen,
    output int     bytes_seen,
    output int     errors_seen
);

    code_t code_q[$];

    code_t bld[$];
    instr_t cur;

    function automatic void emit(input logic [7:0] b, input logic rs, input logic rk);
        code_t c;
        c.code_byte = b;
        c.last = 1'b0;
        c.status = ST_OK;
        c.reloc_start = rs;
        c.reloc_kind = rs ? rk : 1'b0;
        bld.push_back(c);
    endfunction

    function automatic void emit32(input logic [31:0] v, input logic s, input logic rk);
        emit(v[7:0], s, rk);
        emit(v[15:8], 1'b0, 1'b0);
        emit(v[23:16], 1'b0, 1'b0);
        emit(v[31:24], 1'b0, 1'b0);
    endfunction

    function automatic logic [1:0] sib_scale(input logic [3:0] s);
        case (s)
            4'd2: return 2'd1;
            4'd4: return 2'd2;
            4'd8: return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [2:0] alu_dig(input logic [2:0] x);
        case (x)
            3'd0: return 3'd0;
            3'd1: return 3'd1;
            3'd2: return 3'd4;
            3'd3: return 3'd5;
            3'd4: return 3'd6;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [7:0] alu_op(input logic [2:0] x);
        case (x)
            3'd0: return 8'h01;
            3'd1: return 8'h09;
            3'd2: return 8'h21;
            3'd3: return 8'h29;
            3'd4: return 8'h31;
            default: return 8'h39;
        endcase
    endfunction

    function automatic status_t rm_form(input logic [2:0] rf, input logic [1:0] kind,
                                        input logic [2:0] rg);
        logic nb, ni, dsym;
        logic [1:0] md;
        int dsz;
        logic [31:0] d;
        logic [2:0] bc, ic;
        d = cur.mem_disp;
        dsym = cur.sym_flags[0];
        if (kind == KIND_REG)
        begin
            emit({2'b11, rf, rg}, 1'b0, 1'b0);
            return ST_OK;
        end
        if (kind != KIND_MEM) return ST_KIND;
        nb = cur.mem_base >= 4'd8;
        ni = cur.mem_index >= 4'd8;
        if (nb && ni)
        begin
            emit({2'b00, rf, 3'd5}, 1'b0, 1'b0);
            emit32(d, dsym, 1'b0);
            return ST_OK;
        end
        if (nb)
        begin
            md = 2'd0;
            dsz = 4;
        end
        else if (dsym)
        begin
            md = 2'd2;
            dsz = 4;
        end
        else if (d == 32'd0 && cur.mem_base != 4'd5)
        begin
            md = 2'd0;
            dsz = 0;
        end
        else if ((d + 32'd128) < 32'd256)
        begin
            md = 2'd1;
            dsz = 1;
        end
        else
        begin
            md = 2'd2;
            dsz = 4;
        end
        if (!ni || cur.mem_base == 4'd4 || nb)
        begin
            bc = nb ? 3'd5 : cur.mem_base[2:0];
            ic = ni ? 3'd4 : cur.mem_index[2:0];
            emit({md, rf, 3'd4}, 1'b0, 1'b0);
            emit({sib_scale(cur.mem_scale), ic, bc}, 1'b0, 1'b0);
        end
        else
        begin
            emit({md, rf, cur.mem_base[2:0]}, 1'b0, 1'b0);
        end
        if (dsz == 1) emit(d[7:0], 1'b0, 1'b0);
        else if (dsz == 4) emit32(d, dsym, 1'b0);
        return ST_OK;
    endfunction

    function automatic status_t encode_instr();
        logic [4:0] op;
        logic [1:0] n, ka, kb;
        logic [2:0] ra, rb, x;
        logic isym;
        status_t s;
        op = cur.op; n = cur.operand_count; ka = cur.kind_a; kb = cur.kind_b;
        ra = cur.reg_a; rb = cur.reg_b; isym = cur.sym_flags[1];
        if (op == OP_RET || op == OP_NOP)
        begin
            if (n != 0) return ST_COUNT;
            emit(op == OP_RET ? 8'hC3 : 8'h90, 1'b0, 1'b0);
            return ST_OK;
        end
        if (op == OP_INT)
        begin
            if (n != 1) return ST_COUNT;
            if (ka != KIND_IMM || isym) return ST_KIND;
            emit(8'hCD, 1'b0, 1'b0);
            emit(cur.imm_value[7:0], 1'b0, 1'b0);
            return ST_OK;
        end
        if (op >= OP_JMP && op <= OP_JLE)
        begin
            if (n != 1) return ST_COUNT;
            if (ka != KIND_IMM) return ST_KIND;
            if (op == OP_JMP) emit(8'hE9, 1'b0, 1'b0);
            else if (op == OP_CALL) emit(8'hE8, 1'b0, 1'b0);
            else
            begin
                x = 3'(op - OP_JE);
                emit(8'h0F, 1'b0, 1'b0);
                case (x)
                    3'd0: emit(8'h84, 1'b0, 1'b0);
                    3'd1: emit(8'h85, 1'b0, 1'b0);
                    3'd2: emit(8'h8F, 1'b0, 1'b0);
                    3'd3: emit(8'h8D, 1'b0, 1'b0);
                    3'd4: emit(8'h8C, 1'b0, 1'b0);
                    default: emit(8'h8E, 1'b0, 1'b0);
                endcase
            end
            emit32(cur.imm_value, isym, 1'b1);
            return ST_OK;
        end
        if (op == OP_PUSH)
        begin
            if (n != 1) return ST_COUNT;
            if (ka == KIND_REG)
            begin
                emit(8'h50 + {5'd0, ra}, 1'b0, 1'b0);
                return ST_OK;
            end
            if (ka == KIND_IMM)
            begin
                emit(8'h68, 1'b0, 1'b0);
                emit32(cur.imm_value, isym, 1'b0);
                return ST_OK;
            end
            if (ka == KIND_MEM)
            begin
                emit(8'hFF, 1'b0, 1'b0);
                return rm_form(3'd6, ka, ra);
            end
            return ST_KIND;
        end
        if (op == OP_POP)
        begin
            if (n != 1) return ST_COUNT;
            if (ka == KIND_REG)
            begin
                emit(8'h58 + {5'd0, ra}, 1'b0, 1'b0);
                return ST_OK;
            end
            if (ka == KIND_MEM)
            begin
                emit(8'h8F, 1'b0, 1'b0);
                return rm_form(3'd0, ka, ra);
            end
            return ST_KIND;
        end
        if (op >= OP_INC && op <= OP_IDIV)
        begin
            x = 3'(op - OP_INC);
            if (op == OP_IMUL && n == 2)
            begin
                if (ka != KIND_REG) return ST_KIND;
                emit(8'h0F, 1'b0, 1'b0);
                emit(8'hAF, 1'b0, 1'b0);
                return rm_form(ra, kb, rb);
            end
            if (n != 1) return ST_COUNT;
            if (ka != KIND_REG && ka != KIND_MEM) return ST_KIND;
            emit(x < 3'd2 ? 8'hFF : 8'hF7, 1'b0, 1'b0);
            return rm_form(x, ka, ra);
        end
        if (op == OP_LEA)
        begin
            if (n != 2) return ST_COUNT;
            if (ka != KIND_REG || kb != KIND_MEM) return ST_KIND;
            emit(8'h8D, 1'b0, 1'b0);
            return rm_form(ra, kb, rb);
        end
        if (op == OP_MOVZX)
        begin
            if (n != 2) return ST_COUNT;
            if (ka != KIND_REG || (kb != KIND_REG && kb != KIND_MEM)) return ST_KIND;
            emit(8'h0F, 1'b0, 1'b0);
            emit(8'hB6, 1'b0, 1'b0);
            return rm_form(ra, kb, rb);
        end
        if (op == OP_MOV)
        begin
            if (n != 2) return ST_COUNT;
            if (ka == KIND_REG && kb == KIND_IMM)
            begin
                emit(8'hB8 + {5'd0, ra}, 1'b0, 1'b0);
                emit32(cur.imm_value, isym, 1'b0);
                return ST_OK;
            end
            if (ka == KIND_REG && (kb == KIND_REG || kb == KIND_MEM))
            begin
                emit(8'h8B, 1'b0, 1'b0);
                return rm_form(ra, kb, rb);
            end
            if (ka == KIND_MEM && kb == KIND_REG)
            begin
                emit(8'h89, 1'b0, 1'b0);
                return rm_form(rb, ka, ra);
            end
            if (ka == KIND_MEM && kb == KIND_IMM)
            begin
                emit(8'hC7, 1'b0, 1'b0);
                s = rm_form(3'd0, ka, ra);
                if (s != ST_OK) return s;
                emit32(cur.imm_value, isym, 1'b0);
                return ST_OK;
            end
            return ST_KIND;
        end
        if (op >= OP_ADD && op <= OP_CMP)
        begin
            x = 3'(op - OP_ADD);
            if (n != 2) return ST_COUNT;
            if (kb == KIND_IMM)
            begin
                emit(8'h81, 1'b0, 1'b0);
                s = rm_form(alu_dig(x), ka, ra);
                if (s != ST_OK) return s;
                emit32(cur.imm_value, isym, 1'b0);
                return ST_OK;
            end
            if (ka == KIND_REG && (kb == KIND_REG || kb == KIND_MEM))
            begin
                emit(alu_op(x) + 8'd2, 1'b0, 1'b0);
                return rm_form(ra, kb, rb);
            end
            if (ka == KIND_MEM && kb == KIND_REG)
            begin
                emit(alu_op(x), 1'b0, 1'b0);
                return rm_form(rb, ka, ra);
            end
            return ST_KIND;
        end
        return ST_OP;
    endfunction

    task automatic predict_bytes(input instr_t it);
        status_t s;
        code_t c;
        cur = it;
        bld.delete();
        s = encode_instr();
        if (s != ST_OK || bld.size() == 0)
        begin
            c = '0;
            c.last = 1'b1;
            c.status = s;
            code_q.push_back(c);
            errors_seen++;
        end
        else
        begin
            bld[bld.size() - 1].last = 1'b1;
            foreach (bld[k]) code_q.push_back(bld[k]);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        instr_seen = 0;
        bytes_seen = 0;
        errors_seen = 0;
    end

    always @(posedge clk)
    begin
        code_t e;
        if (rst_n)
        begin
            if (instr_valid && !instr_stall)
            begin
                predict_bytes(instr);
                instr_seen++;
            end
            if (code_valid && !code_stall)
            begin
                bytes_seen++;
                if (code_q.size() == 0)
                begin
                    $error("unexpected code beat %h", code);
                    fail_count++;
                end
                else
                begin
                    e = code_q.pop_front();
                    if (code.code_byte !== e.code_byte)
                    begin
                        $error("code_byte expected %h actual %h", e.code_byte, code.code_byte);
                        fail_count++;
                    end
                    if (code.last !== e.last)
                    begin
                        $error("last expected %b actual %b", e.last, code.last);
                        fail_count++;
                    end
                    if (code.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, code.status);
                        fail_count++;
                    end
                    if (code.reloc_start !== e.reloc_start)
                    begin
                        $error("reloc_start expected %b actual %b", e.reloc_start,
                               code.reloc_start);
                        fail_count++;
                    end
                    if (code.reloc_kind !== e.reloc_kind)
                    begin
                        $error("reloc_kind expected %b actual %b", e.reloc_kind,
                               code.reloc_kind);
                        fail_count++;
                    end
                end
            end
            pending = code_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import ia32e_pkg::*;

    logic   clk;
    logic   rst_n;
    logic   instr_valid;
    logic   instr_stall;
    instr_t instr;
    logic   code_valid;
    logic   code_stall;
    code_t  code;
    int     fail_count, pending, instr_seen, bytes_seen, errors_seen;
    int     send_idle, recv_idle;
    int     hold_off;
    int     cycles;

    ia32_instruction_encoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .instr_valid(instr_valid), .instr_stall(instr_stall), .instr(instr),
        .code_valid(code_valid), .code_stall(code_stall), .code(code)
    );

    ia32_encoder_checker chk (
        .clk(clk), .rst_n(rst_n),
        .instr_valid(instr_valid), .instr_stall(instr_stall), .instr(instr),
        .code_valid(code_valid), .code_stall(code_stall), .code(code),
        .fail_count(fail_count), .pending(pending), .instr_seen(instr_seen),
        .bytes_seen(bytes_seen), .errors_seen(errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall, plus long hold-off
    initial
    begin
        code_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                code_stall <= 1'b1;
            end
            else
            begin
                code_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    function automatic logic [31:0] pick_disp();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom_range(255) - 128;
            2: return 32'h7FFFFFFF;
            3: return 32'h80000000;
            4: return 32'd128;
            5: return 32'hFFFFFF7F;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t rand_instr();
        instr_t it;
        it.reg_a = 3'($urandom_range(7));
        it.reg_b = 3'($urandom_range(7));
        it.mem_disp = pick_disp();
        it.imm_value = $urandom;
        it.sym_flags = 2'($urandom_range(3));
        it.mem_scale = 4'($urandom_range(15));
        it.mem_base = ($urandom_range(3) == 0) ? 4'(8 + $urandom_range(7))
                                               : 4'($urandom_range(7));
        it.mem_index = ($urandom_range(3) == 0) ? 4'(8 + $urandom_range(7))
                                                : 4'($urandom_range(7));
        if ($urandom_range(9) < 8)
        begin
            it.op = 5'($urandom_range(29));
            if (it.op <= OP_NOP) it.operand_count = 2'd0;
            else if (it.op <= OP_POP) it.operand_count = 2'd1;
            else if (it.op >= OP_LEA) it.operand_count = 2'd2;
            else it.operand_count = (it.op == OP_IMUL && $urandom_range(1)) ? 2'd2 : 2'd1;
            it.kind_a = 2'($urandom_range(2));
            it.kind_b = 2'($urandom_range(2));
            if (it.op >= OP_INT && it.op <= OP_JLE) it.kind_a = KIND_IMM;
        end
        else
        begin
            it.op = 5'($urandom);
            it.operand_count = 2'($urandom);
            it.kind_a = 2'($urandom);
            it.kind_b = 2'($urandom);
        end
        return it;
    endfunction

    task automatic send(input instr_t it);
        while ($urandom_range(99) < send_idle)
        begin
            instr_valid <= 1'b0;
            @(negedge clk);
        end
        instr_valid <= 1'b1;
        instr <= it;
        @(posedge clk);
        while (instr_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        instr_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        instr_t it;
        instr_valid = 1'b0;
        instr = '0;
        hold_off = 0;
        send_idle = 11;
        recv_idle = 75;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        it = '0; it.op = OP_RET; send(it);
        it.op = OP_NOP; send(it);
        it.operand_count = 1; send(it);
        it = '0; it.op = OP_INT; it.operand_count = 1; it.kind_a = KIND_IMM;
        it.imm_value = 32'h7FFFFF80; send(it);
        it.sym_flags = 2'b10; send(it);
        it = '0; it.op = OP_JMP; it.operand_count = 1; it.kind_a = KIND_IMM;
        it.imm_value = 32'h80000000; it.sym_flags = 2'b10; send(it);
        it.op = OP_JLE; it.sym_flags = 2'b11; it.imm_value = 32'hFFFFFFFF; send(it);
        it = '0; it.op = OP_PUSH; it.operand_count = 1; it.kind_a = 2'd3; send(it);
        it.kind_a = KIND_MEM; it.mem_base = 4'd5; it.mem_index = 4'd15; send(it);
        it.mem_base = 4'd4; it.mem_disp = 32'h7F; send(it);
        it.mem_base = 4'd15; it.mem_index = 4'd15; it.sym_flags = 2'b01; send(it);
        it.mem_base = 4'd15; it.mem_index = 4'd4; it.mem_scale = 4'd8; send(it);
        it = '0; it.op = OP_MOV; it.operand_count = 2; it.kind_a = KIND_MEM;
        it.kind_b = KIND_IMM; it.mem_base = 4'd7; it.mem_index = 4'd6; it.mem_scale = 4'd4;
        it.mem_disp = 32'hFFFFFF80; it.imm_value = 32'hA5A5A5A5; it.sym_flags = 2'b11;
        it.reg_a = 3'd7; it.reg_b = 3'd7; send(it);
        it.mem_disp = 32'h80000000; it.sym_flags = 2'b00; send(it);
        it = '0; it.op = OP_CMP; it.operand_count = 2; it.kind_a = KIND_IMM;
        it.kind_b = KIND_IMM; send(it);
        it.kind_a = KIND_MEM; it.kind_b = KIND_REG; it.mem_base = 4'd0; send(it);
        it.op = OP_ADD; it.operand_count = 3; send(it);
        it = '0; it.op = OP_IMUL; it.operand_count = 2; it.kind_b = KIND_IMM; send(it);
        it.kind_b = KIND_MEM; it.mem_base = 4'd5; it.mem_index = 4'd2; send(it);
        it = '0; it.op = OP_MOVZX; it.operand_count = 2; it.kind_b = KIND_MEM;
        it.mem_base = 4'd8; it.mem_index = 4'd8; send(it);
        it.op = OP_LEA; send(it);
        it.op = 5'd31; send(it);
        it.op = 5'd30; send(it);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 11 : (ph == 1) ? 75 : 0;
            recv_idle = (ph == 0) ? 75 : (ph == 1) ? 11 : 0;
            for (int k = 0; k < 100; k++)
            begin
                if (ph == 2 && k == 10) hold_off = 300;
                send(rand_instr());
            end
            drain();
        end

        $display("Covered %0d instructions, %0d code bytes, %0d error results.",
                 instr_seen, bytes_seen, errors_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
